// ===== hdl/tce_pkg.sv =====
// Shared types and constants for the text console engine.
`timescale 1ns / 1ps
package tce_pkg;

  typedef logic [15:0] cell_t;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_WRITE = 2'd3
  } mode_e;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] ATTR_RESET   = 8'h07;
  localparam int unsigned POS_W       = 11;

endpackage

// ===== hdl/text_console_engine.sv =====
// Top level of the text console engine: sequencer, cursor and screen memory.
//
// A request is taken at a rising edge where start is high and busy is low.
// The fields mode_i, char_code_i, cell_row_i, cell_col_i and entry_data_i
// must be valid in that cycle only. Every request produces exactly one
// result, shown on cursor_pos_o, read_entry_o and scrolled_o for a single
// cycle while done_o is high; the receiver cannot hold results off.
// A put character, newline without scroll, cell write or a read outside the
// screen gives its result in the cycle after the request; a cell read inside
// the screen goes through the S_READ state and the registered read port of
// the screen memory before its result is registered. A clear sweeps every
// cell once. A scroll copies the lower rows up one row, reading through the
// read port and writing through the write port, and then blanks the bottom row.
// A new request may be taken in the same cycle that done_o is high.
// After reset the block runs a clearing pass that fills the screen with
// spaces in the reset attribute; busy stays high
// meanwhile. The attribute register is written through cfg_we_i at any time.
module text_console_engine import tce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  char_code_i,
  input  logic [4:0]  cell_row_i,
  input  logic [6:0]  cell_col_i,
  input  logic [15:0] entry_data_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [10:0] cursor_pos_o,
  output logic [15:0] read_entry_o,
  output logic        scrolled_o
);

  localparam int Cells    = ROWS * COLUMNS;
  localparam int AddrW    = $clog2(Cells);
  localparam int RowW     = $clog2(ROWS);
  localparam int ColW     = $clog2(COLUMNS);
  localparam int LastBase = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_COPY,
    S_FILL
  } state_e;

  state_e            state_q, state_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic [AddrW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0]  dst_q, dst_d;
  logic              wv_q, wv_d;
  logic              scr_q, scr_d;
  logic [7:0]        attr_q, attr_d;
  logic              done_q, done_d;
  cell_t             rd_entry_q, rd_entry_d;
  logic              scrolled_q, scrolled_d;

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  cell_t             mem_wdata;
  logic [AddrW-1:0]  mem_raddr;
  cell_t             mem_rdata;

  logic              accept;
  logic              in_range;
  logic [AddrW-1:0]  cell_addr;
  logic              last_col;
  logic              last_row;
  cell_t             blank;

  assign accept    = start && !busy;
  assign in_range  = (32'(cell_row_i) < ROWS) && (32'(cell_col_i) < COLUMNS);
  assign cell_addr = AddrW'(32'(cell_row_i) * COLUMNS + 32'(cell_col_i));
  assign last_col  = (col_q == ColW'(COLUMNS - 1));
  assign last_row  = (row_q == RowW'(ROWS - 1));
  assign blank     = (state_q == S_INIT) ? {ATTR_RESET, SPACE_CHAR} : {attr_q, SPACE_CHAR};

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    dst_d      = dst_q;
    wv_d       = 1'b0;
    scr_d      = scr_q;
    attr_d     = cfg_we_i ? cfg_wdata_i : attr_q;
    done_d     = 1'b0;
    rd_entry_d = rd_entry_q;
    scrolled_d = scrolled_q;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q;
    mem_wdata  = blank;
    mem_raddr  = cell_addr;

    // A pending copy write from the scroll pipeline always wins the port.
    if (wv_q) begin
      mem_we    = 1'b1;
      mem_waddr = dst_q;
      mem_wdata = mem_rdata;
    end

    case (state_q)
      S_INIT: begin
        mem_we = 1'b1;
        if (cnt_q == AddrW'(Cells - 1)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          rd_entry_d = '0;
          scrolled_d = 1'b0;
          case (mode_e'(mode_i))
            MODE_PUT: begin
              if (char_code_i != NEWLINE_CHAR) begin
                mem_we    = 1'b1;
                mem_waddr = pos_q;
                mem_wdata = {attr_q, char_code_i};
              end
              if (char_code_i == NEWLINE_CHAR || last_col) begin
                col_d = '0;
                if (last_row) begin
                  pos_d   = AddrW'(LastBase);
                  cnt_d   = AddrW'(COLUMNS);
                  scr_d   = 1'b1;
                  state_d = S_COPY;
                end else begin
                  row_d  = row_q + 1'b1;
                  pos_d  = pos_q - AddrW'(col_q) + AddrW'(COLUMNS);
                  done_d = 1'b1;
                end
              end else begin
                col_d  = col_q + 1'b1;
                pos_d  = pos_q + 1'b1;
                done_d = 1'b1;
              end
            end
            MODE_CLEAR: begin
              cnt_d   = '0;
              scr_d   = 1'b0;
              state_d = S_FILL;
            end
            MODE_READ: begin
              if (in_range) begin
                state_d = S_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            MODE_WRITE: begin
              if (in_range) begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr;
                mem_wdata = entry_data_i;
              end
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        rd_entry_d = mem_rdata;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      S_COPY: begin
        // Read one row below, write it back in the next cycle.
        mem_raddr = cnt_q;
        wv_d      = 1'b1;
        dst_d     = cnt_q - AddrW'(COLUMNS);
        if (cnt_q == AddrW'(Cells - 1)) begin
          cnt_d   = AddrW'(LastBase);
          state_d = S_FILL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FILL: begin
        if (!wv_q) begin
          mem_we = 1'b1;
          if (cnt_q == AddrW'(Cells - 1)) begin
            done_d     = 1'b1;
            scrolled_d = scr_q;
            state_d    = S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      row_q      <= '0;
      col_q      <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      dst_q      <= '0;
      wv_q       <= 1'b0;
      scr_q      <= 1'b0;
      attr_q     <= ATTR_RESET;
      done_q     <= 1'b0;
      rd_entry_q <= '0;
      scrolled_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      dst_q      <= dst_d;
      wv_q       <= wv_d;
      scr_q      <= scr_d;
      attr_q     <= attr_d;
      done_q     <= done_d;
      rd_entry_q <= rd_entry_d;
      scrolled_q <= scrolled_d;
    end
  end

  tce_screen_ram #(
    .Depth (Cells),
    .AddrW (AddrW)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign cursor_pos_o = POS_W'(pos_q);
  assign read_entry_o = rd_entry_q;
  assign scrolled_o   = scrolled_q;

endmodule

// ===== hdl/tce_screen_ram.sv =====
// Screen memory: one write port and one registered read port.
`timescale 1ns / 1ps
module tce_screen_ram import tce_pkg::*; #(
  parameter int Depth = 2000,
  parameter int AddrW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  cell_t            wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output cell_t            rdata_o
);

  cell_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== tb/text_console_engine_test.sv =====
// Self-checking testbench for the text console engine with its own screen and cursor predictor.
`timescale 1ns / 1ps
module text_console_engine_test;
  import tce_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = ROWS * COLUMNS;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 140;
  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct {
    mode_e       mode;
    logic [7:0]  ch;
    logic [4:0]  row;
    logic [6:0]  col;
    logic [15:0] data;
  } request_t;

  typedef struct {
    logic [10:0] cursor_pos;
    logic [15:0] read_entry;
    logic        scrolled;
  } console_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode_i = MODE_PUT;
  logic [7:0]  char_code_i = '0;
  logic [4:0]  cell_row_i = '0;
  logic [6:0]  cell_col_i = '0;
  logic [15:0] entry_data_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        done_o;
  logic [10:0] cursor_pos_o;
  logic [15:0] read_entry_o;
  logic        scrolled_o;

  // Predictor state: screen image, cursor and the attribute register.
  logic [15:0] screen_img [CELLS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  attr_reg;

  request_t        pending_requests[$];
  console_result_t expected_results[$];
  request_t        held;
  int              wait_left = 0;
  int              gap;
  int              no_gap_left = 0;
  int              requests_issued = 0;
  int              results_checked = 0;
  int              errors = 0;
  longint          cycles = 0;

  text_console_engine #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .entry_data_i(entry_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .cursor_pos_o(cursor_pos_o),
    .read_entry_o(read_entry_o),
    .scrolled_o  (scrolled_o)
  );

  always #10 clk_i = ~clk_i;

  // Moves the cursor to the start of the next row and scrolls at the bottom.
  function automatic logic advance_line(input logic [15:0] blank);
    cur_col = 0;
    if (cur_row >= ROWS - 1) begin
      cur_row = ROWS - 1;
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_img[i] = screen_img[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen_img[i] = blank;
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic console_result_t console_step(input request_t rq);
    console_result_t r;
    logic [15:0] blank;
    logic in_range;
    int addr;
    r.cursor_pos = '0;
    r.read_entry = '0;
    r.scrolled = 1'b0;
    blank = {attr_reg, SPACE_CHAR};
    in_range = (rq.row < ROWS) && (rq.col < COLUMNS);
    addr = rq.row * COLUMNS + rq.col;
    case (rq.mode)
      MODE_PUT: begin
        if (rq.ch == NEWLINE_CHAR) begin
          r.scrolled = advance_line(blank);
        end else begin
          screen_img[cur_row * COLUMNS + cur_col] = {attr_reg, rq.ch};
          cur_col++;
          if (cur_col >= COLUMNS) r.scrolled = advance_line(blank);
        end
      end
      MODE_CLEAR: begin
        foreach (screen_img[i]) screen_img[i] = blank;
      end
      MODE_READ: begin
        if (in_range) r.read_entry = screen_img[addr];
      end
      default: begin
        if (in_range) screen_img[addr] = rq.data;
      end
    endcase
    r.cursor_pos = 11'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic request_t random_request();
    request_t rq;
    rq.mode = mode_e'($urandom_range(0, 3));
    rq.ch = 8'($urandom_range(0, 255));
    rq.row = 5'($urandom_range(0, 31));
    rq.col = 7'($urandom_range(0, 127));
    rq.data = 16'($urandom_range(0, 65535));
    return rq;
  endfunction

  task automatic queue_request(input request_t rq);
    pending_requests.push_back(rq);
    requests_issued++;
  endtask

  task automatic queue_cell(input mode_e mode, input int row, input int col,
                            input logic [15:0] data);
    request_t rq;
    rq = random_request();
    rq.mode = mode;
    rq.row = 5'(row);
    rq.col = 7'(col);
    rq.data = data;
    queue_request(rq);
  endtask

  task automatic queue_char(input logic [7:0] ch);
    request_t rq;
    rq = random_request();
    rq.mode = MODE_PUT;
    rq.ch = ch;
    queue_request(rq);
  endtask

  // Mostly well-formed text and cell traffic, with some fully random requests and clears.
  task automatic queue_random_phase(input int count);
    int n;
    int len;
    int row;
    int col;
    request_t rq;
    n = 0;
    while (n < count) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          len = $urandom_range(1, 90);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) queue_char(NEWLINE_CHAR);
            else if ($urandom_range(0, 7) == 0) queue_char(8'($urandom_range(0, 255)));
            else queue_char(8'($urandom_range(32, 126)));
          end
          n += len;
        end
        6, 7, 8, 9, 10: begin
          queue_request(random_request());
          n++;
        end
        11, 12, 13: begin
          queue_cell(MODE_READ, $urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1),
                     16'($urandom_range(0, 65535)));
          n++;
        end
        14, 15, 16: begin
          row = $urandom_range(0, ROWS - 1);
          col = $urandom_range(0, COLUMNS - 1);
          queue_cell(MODE_WRITE, row, col, 16'($urandom_range(0, 65535)));
          queue_cell(MODE_READ, row, col, 16'($urandom_range(0, 65535)));
          n += 2;
        end
        17, 18: begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) queue_char(NEWLINE_CHAR);
          n += len;
        end
        default: begin
          rq = random_request();
          rq.mode = MODE_CLEAR;
          queue_request(rq);
          n++;
        end
      endcase
    end
  endtask

  task automatic write_attribute(input logic [7:0] value);
    wait (results_checked == requests_issued && pending_requests.size() == 0);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    attr_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Driver: holds each request on the ports until the engine takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      wait_left <= 0;
    end else if (start && !busy) begin
      expected_results.push_back(console_step(held));
      if (no_gap_left > 0) begin
        gap = 0;
        no_gap_left--;
      end else begin
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 19) == 0) no_gap_left = $urandom_range(10, 40);
      end
      if (gap == 0 && pending_requests.size() > 0) begin
        held = pending_requests.pop_front();
        mode_i <= held.mode;
        char_code_i <= held.ch;
        cell_row_i <= held.row;
        cell_col_i <= held.col;
        entry_data_i <= held.data;
      end else begin
        start <= 1'b0;
        wait_left <= gap;
      end
    end else if (!start) begin
      if (wait_left > 0) begin
        wait_left <= wait_left - 1;
      end else if (pending_requests.size() > 0) begin
        held = pending_requests.pop_front();
        mode_i <= held.mode;
        char_code_i <= held.ch;
        cell_row_i <= held.row;
        cell_col_i <= held.col;
        entry_data_i <= held.data;
        start <= 1'b1;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    console_result_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: cursor_pos %0d read_entry %h scrolled %b",
                 $time, cursor_pos_o, read_entry_o, scrolled_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (cursor_pos_o !== exp_r.cursor_pos) begin
          $display("%0t: cursor_pos expected %0d actual %0d",
                   $time, exp_r.cursor_pos, cursor_pos_o);
          errors++;
        end
        if (read_entry_o !== exp_r.read_entry) begin
          $display("%0t: read_entry expected %h actual %h",
                   $time, exp_r.read_entry, read_entry_o);
          errors++;
        end
        if (scrolled_o !== exp_r.scrolled) begin
          $display("%0t: scrolled expected %b actual %b", $time, exp_r.scrolled, scrolled_o);
          errors++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("text_console_engine_test NOT OK");
      $finish;
    end
  end

  initial begin
    request_t rq;
    foreach (screen_img[i]) screen_img[i] = {ATTR_RESET, SPACE_CHAR};
    cur_row = 0;
    cur_col = 0;
    attr_reg = ATTR_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (busy === 1'b0);
    @(negedge clk_i);

    // Directed part under the reset attribute: corners, out-of-range cells,
    // bytes above 127, newline and clear.
    queue_cell(MODE_READ, 0, 0, 16'h0000);
    queue_cell(MODE_READ, ROWS - 1, COLUMNS - 1, 16'hFFFF);
    queue_cell(MODE_READ, ROWS, 0, 16'h0000);
    queue_cell(MODE_READ, 0, COLUMNS, 16'hFFFF);
    queue_cell(MODE_READ, 31, 127, 16'h0000);
    queue_char(8'h41);
    queue_char(8'hFF);
    queue_char(8'h00);
    queue_char(8'h80);
    queue_cell(MODE_READ, 0, 1, 16'h0000);
    queue_cell(MODE_READ, 0, 3, 16'h0000);
    queue_cell(MODE_WRITE, ROWS - 1, COLUMNS - 1, 16'hFFFF);
    queue_cell(MODE_READ, ROWS - 1, COLUMNS - 1, 16'h0000);
    queue_cell(MODE_WRITE, 0, 0, 16'h0000);
    queue_cell(MODE_WRITE, 31, 127, 16'h1234);
    queue_cell(MODE_WRITE, 0, COLUMNS, 16'hABCD);
    queue_cell(MODE_READ, 0, 0, 16'hFFFF);
    queue_char(NEWLINE_CHAR);
    queue_char(8'h7E);
    rq = random_request();
    rq.mode = MODE_CLEAR;
    queue_request(rq);
    queue_cell(MODE_READ, ROWS - 1, COLUMNS - 1, 16'h0000);
    queue_cell(MODE_READ, 1, 0, 16'h0000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) write_attribute(8'h00);
      else if (p == 1) write_attribute(8'hFF);
      else write_attribute(8'($urandom_range(0, 255)));
      queue_random_phase(ITEMS_PER_PHASE);
    end

    wait (results_checked == requests_issued && pending_requests.size() == 0);
    repeat (CELLS + 20) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("text_console_engine_test OK");
    end else begin
      $display("text_console_engine_test NOT OK");
    end
    $finish;
  end

endmodule
